// ----- design/tppc_pkg.sv -----
`default_nettype none

package tppc_pkg;

	// item and result field widths
	localparam int SAMPLE_W = 12;
	localparam int TEMP_W   = 17;
	localparam int DRIVE_W  = 15;
	localparam int PWM_W    = 10;

	// PID datapath
	localparam int SETP_W      = 8;
	localparam int FRAC_W      = 8;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC_W = 12;
	localparam int ERR_W       = SETP_W + FRAC_W;
	localparam int ACC_W       = 32;
	localparam int DIGIT_W     = 16;

	localparam int unsigned TEMP_FULL      = 128000;  // 500 degrees in Q9.8
	localparam int unsigned DRIVE_MAX      = 25600;   // 100 percent in Q7.8
	localparam int unsigned PWM_SCALE      = 10;
	localparam int          PWM_PROD_W     = DRIVE_W + 4;
	localparam int unsigned FAN_ON_MARGIN  = 256;
	localparam int unsigned FAN_OFF_MARGIN = 128;

	// register port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SETPOINT = 2'd0;
	localparam reg_idx_t REG_GAIN_P   = 2'd1;
	localparam reg_idx_t REG_GAIN_I   = 2'd2;
	localparam reg_idx_t REG_GAIN_D   = 2'd3;

	localparam logic [SETP_W-1:0] SETPOINT_RST = 8'd50;
	localparam logic [GAIN_W-1:0] GAIN_P_RST   = 16'd942;
	localparam logic [GAIN_W-1:0] GAIN_I_RST   = 16'd303;
	localparam logic [GAIN_W-1:0] GAIN_D_RST   = 16'd7782;

	typedef struct packed {
		logic [SETP_W-1:0] setpoint;
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
	} cfg_t;

	typedef struct packed {
		logic                start;
		logic                sample_valid;
		logic [SAMPLE_W-1:0] sample;
	} win_req_t;

endpackage

`default_nettype wire

// ----- design/tppc_regs.sv -----
`default_nettype none

module tppc_regs import tppc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx = paddr[ADDR_W-1:2];
	assign wr  = psel & penable & pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint <= SETPOINT_RST;
			cfg_q.gain_p   <= GAIN_P_RST;
			cfg_q.gain_i   <= GAIN_I_RST;
			cfg_q.gain_d   <= GAIN_D_RST;
		end else if (wr) begin
			case (idx)
				REG_SETPOINT: cfg_q.setpoint <= pwdata[SETP_W-1:0];
				REG_GAIN_P:   cfg_q.gain_p   <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:   cfg_q.gain_i   <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:   cfg_q.gain_d   <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETPOINT: prdata = DATA_W'(cfg_q.setpoint);
			REG_GAIN_P:   prdata = DATA_W'(cfg_q.gain_p);
			REG_GAIN_I:   prdata = DATA_W'(cfg_q.gain_i);
			REG_GAIN_D:   prdata = DATA_W'(cfg_q.gain_d);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/tppc_window.sv -----
`default_nettype none

module tppc_window import tppc_pkg::*; #(
	parameter int unsigned WINDOW_LEN = 10,
	parameter int unsigned ADC_BITS   = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  win_req_t          req,
	output logic              done,
	output logic [TEMP_W-1:0] temperature
);

	localparam int unsigned ADC_MAX    = (1 << ADC_BITS) - 1;
	localparam int unsigned PORT_MAX   = (1 << SAMPLE_W) - 1;
	localparam int unsigned SAMPLE_MAX = (ADC_MAX > PORT_MAX) ? PORT_MAX : ADC_MAX;
	localparam int unsigned SUM_W      = $clog2(WINDOW_LEN * SAMPLE_MAX + 1);
	localparam int unsigned SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam longint unsigned DIVISOR = longint'(ADC_MAX) * WINDOW_LEN;
	localparam int unsigned D_W        = $clog2(DIVISOR + 1);
	// floor(2^SUM_W * 500 deg / divisor); the product undershoots by at most one
	localparam longint unsigned RECIP  = ((64'd1 << SUM_W) * TEMP_FULL) / DIVISOR;
	localparam int unsigned RECIP_W    = $clog2(RECIP + 1);
	localparam int unsigned QP_W       = SUM_W + RECIP_W;
	localparam int unsigned NUM_W      = SUM_W + TEMP_W;
	localparam int unsigned QD_W       = TEMP_W + D_W;

	localparam logic [2:0] W_IDLE = 3'd0;
	localparam logic [2:0] W_SUM  = 3'd1;
	localparam logic [2:0] W_MUL  = 3'd2;
	localparam logic [2:0] W_QD   = 3'd3;
	localparam logic [2:0] W_FIX  = 3'd4;

	logic [SAMPLE_W-1:0] mem [WINDOW_LEN];
	logic [SAMPLE_W-1:0] rd_q;

	logic [2:0]          state_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                wrapped_q;
	logic [SUM_W-1:0]    sum_q;
	logic [TEMP_W-1:0]   temp_q;
	logic                done_q;

	logic [SAMPLE_W-1:0] s_q;
	logic [QP_W-1:0]     qprod_q;
	logic [NUM_W-1:0]    num_q;
	logic [TEMP_W-1:0]   q0_q;
	logic [QD_W-1:0]     qd_q;

	logic [SAMPLE_W-1:0] sample_sat;
	logic [SAMPLE_W-1:0] old_sample;
	logic [SUM_W-1:0]    sum_next;
	logic [NUM_W-1:0]    rem;
	logic                wr_en;

	assign done        = done_q;
	assign temperature = temp_q;

	always_comb begin
		if (32'(req.sample) > ADC_MAX)
			sample_sat = SAMPLE_W'(ADC_MAX);
		else
			sample_sat = req.sample;
	end

	// slots fill in order, so an entry is live once the slot pointer has wrapped
	assign old_sample = wrapped_q ? rd_q : '0;
	assign sum_next   = sum_q - SUM_W'(old_sample) + SUM_W'(s_q);
	assign rem        = num_q - NUM_W'(qd_q);
	assign wr_en      = (state_q == W_SUM);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[slot_q] <= s_q;
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= W_IDLE;
			slot_q    <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
			temp_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				W_IDLE: begin
					if (req.start) begin
						if (req.sample_valid)
							state_q <= W_SUM;
						else
							done_q <= 1'b1;
					end
				end
				W_SUM: begin
					sum_q <= sum_next;
					if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
						slot_q    <= '0;
						wrapped_q <= 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
					state_q <= W_MUL;
				end
				W_MUL: state_q <= W_QD;
				W_QD:  state_q <= W_FIX;
				W_FIX: begin
					temp_q  <= q0_q + TEMP_W'(rem >= NUM_W'(DIVISOR));
					done_q  <= 1'b1;
					state_q <= W_IDLE;
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == W_IDLE && req.start)
			s_q <= sample_sat;
		if (state_q == W_MUL) begin
			qprod_q <= QP_W'(sum_q) * QP_W'(RECIP);
			num_q   <= NUM_W'(sum_q) * NUM_W'(TEMP_FULL);
		end
		if (state_q == W_QD) begin
			q0_q <= TEMP_W'(qprod_q >> SUM_W);
			qd_q <= QD_W'(TEMP_W'(qprod_q >> SUM_W)) * QD_W'(DIVISOR);
		end
	end

endmodule

`default_nettype wire

// ----- design/tppc_pid.sv -----
`default_nettype none

module tppc_pid import tppc_pkg::*; #(
	parameter int unsigned CONTROL_RATE_HZ = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [TEMP_W-1:0]  temperature,
	input  cfg_t               cfg,
	output logic               done,
	output logic [DRIVE_W-1:0] drive
);

	localparam int unsigned RATE_W   = $clog2(CONTROL_RATE_HZ + 1);
	localparam int unsigned DIV_K    = RATE_W + DIGIT_W;
	// x < rate * 2^16 <= 2^DIV_K, so x * RECIP >> DIV_K undershoots by at most one
	localparam longint unsigned RECIP = (64'd1 << DIV_K) / CONTROL_RATE_HZ;
	localparam int unsigned RECIP_W  = DIV_K + 1;
	localparam int unsigned QM_W     = DIV_K + RECIP_W;
	localparam int unsigned PP_W     = GAIN_W + ERR_W;
	localparam int unsigned PI_W     = GAIN_W + ACC_W;
	localparam int unsigned N_DIG    = PI_W / DIGIT_W;
	localparam int unsigned DIG_W    = $clog2(N_DIG);
	localparam int unsigned GDR_W    = GAIN_W + RATE_W;
	localparam int unsigned DIFF_W   = ERR_W + 1;
	localparam int unsigned PD_W     = GDR_W + 1 + DIFF_W;
	localparam int unsigned PS_W     = ((PD_W > PI_W) ? PD_W : PI_W) + 2;
	localparam int unsigned DQ_W     = PS_W - 1 - GAIN_FRAC_W;

	localparam logic [2:0] P_IDLE  = 3'd0;
	localparam logic [2:0] P_MUL   = 3'd1;
	localparam logic [2:0] P_DMUL  = 3'd2;
	localparam logic [2:0] P_DIVA  = 3'd3;
	localparam logic [2:0] P_DIVB  = 3'd4;
	localparam logic [2:0] P_SUM   = 3'd5;
	localparam logic [2:0] P_CLAMP = 3'd6;

	logic [2:0]               state_q;
	logic [ACC_W-1:0]         acc_q;
	logic [ERR_W-1:0]         last_q;
	logic [DRIVE_W-1:0]       drive_q;
	logic                     done_q;
	logic [DIG_W-1:0]         dig_q;

	logic [ERR_W-1:0]         e_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [PP_W-1:0]          pp_q;
	logic [PI_W-1:0]          pi_q;
	logic [GDR_W-1:0]         gdr_q;
	logic signed [PD_W-1:0]   pd_q;
	logic [RATE_W-1:0]        rem_q;
	logic [PI_W-1:0]          quot_q;
	logic [QM_W-1:0]          qm_q;
	logic [DIV_K-1:0]         x_q;
	logic [PS_W-1:0]          ps_q;

	logic [ERR_W-1:0]         sp;
	logic [ERR_W-1:0]         err;
	logic                     above;
	logic [ACC_W:0]           acc_sum;
	logic [DIV_K-1:0]         x;
	logic [DIGIT_W-1:0]       qdig;
	logic [DIV_K-1:0]         r0;
	logic                     rfix;
	logic [DQ_W-1:0]          dq;

	assign done  = done_q;
	assign drive = drive_q;

	assign sp      = {cfg.setpoint, {FRAC_W{1'b0}}};
	assign above   = TEMP_W'(sp) < temperature;
	assign err     = sp - ERR_W'(temperature);
	assign acc_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(err);

	// one 16-bit digit of gain_i * acc / rate per P_DIVA / P_DIVB pass
	assign x    = {rem_q, pi_q[PI_W-1 -: DIGIT_W]};
	assign qdig = DIGIT_W'(qm_q >> DIV_K);
	assign r0   = x_q - DIV_K'(DIV_K'(qdig) * DIV_K'(CONTROL_RATE_HZ));
	assign rfix = r0 >= DIV_K'(CONTROL_RATE_HZ);

	assign dq = ps_q[PS_W-2:GAIN_FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			acc_q   <= '0;
			last_q  <= '0;
			drive_q <= '0;
			done_q  <= 1'b0;
			dig_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				P_IDLE: begin
					if (start) begin
						if (above) begin
							// too warm: no drive, integrator and history hold
							drive_q <= '0;
							done_q  <= 1'b1;
						end else begin
							acc_q   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
							last_q  <= err;
							state_q <= P_MUL;
						end
					end
				end
				P_MUL: state_q <= P_DMUL;
				P_DMUL: begin
					dig_q   <= '0;
					state_q <= P_DIVA;
				end
				P_DIVA: state_q <= P_DIVB;
				P_DIVB: begin
					if (dig_q == DIG_W'(N_DIG - 1)) begin
						state_q <= P_SUM;
					end else begin
						dig_q   <= dig_q + 1'b1;
						state_q <= P_DIVA;
					end
				end
				P_SUM: state_q <= P_CLAMP;
				P_CLAMP: begin
					if (ps_q[PS_W-1] || ps_q == '0)
						drive_q <= '0;
					else if (dq > DQ_W'(DRIVE_MAX))
						drive_q <= DRIVE_W'(DRIVE_MAX);
					else
						drive_q <= DRIVE_W'(dq);
					done_q  <= 1'b1;
					state_q <= P_IDLE;
				end
				default: state_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			P_IDLE: begin
				e_q    <= err;
				diff_q <= DIFF_W'(err) - DIFF_W'(last_q);
			end
			P_MUL: begin
				pp_q  <= PP_W'(cfg.gain_p) * PP_W'(e_q);
				pi_q  <= PI_W'(cfg.gain_i) * PI_W'(acc_q);
				gdr_q <= GDR_W'(cfg.gain_d) * GDR_W'(CONTROL_RATE_HZ);
			end
			P_DMUL: begin
				pd_q   <= PD_W'($signed({1'b0, gdr_q})) * PD_W'(diff_q);
				rem_q  <= '0;
				quot_q <= '0;
			end
			P_DIVA: begin
				qm_q <= QM_W'(x) * QM_W'(RECIP);
				x_q  <= x;
			end
			P_DIVB: begin
				quot_q <= {quot_q[PI_W-DIGIT_W-1:0], qdig + DIGIT_W'(rfix)};
				rem_q  <= rfix ? RATE_W'(r0 - DIV_K'(CONTROL_RATE_HZ)) : RATE_W'(r0);
				pi_q   <= pi_q << DIGIT_W;
			end
			P_SUM: begin
				ps_q <= PS_W'(pp_q) + PS_W'(quot_q) + PS_W'(pd_q);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ----- design/temperature_pid_pwm_controller_core.sv -----
`default_nettype none

// channel | direction | handshake              | payload
// in      | in        | in_valid / in_stall    | kind, sample_valid, adc_sample
// out     | out       | out_valid / out_stall  | temperature_q8, drive_q8, pwm_compare, fan_on
// cfg     | in        | psel, penable, pwrite  | paddr, pwdata, prdata (pready tied high)
//
// One item at a time. An accepted item runs the window's sum, multiply, quotient and
// fix-up steps, skipped for a tick without a sample; a control tick then runs
// the PID's multiply, derivative multiply, three-digit integral division, sum and
// clamp, all skipped above the setpoint; fan and output steps follow. Reset clears the
// control state; the window lives in a WINDOW_LEN-entry RAM, a wrap flag for its clear.
// A new item is taken while the previous result still waits on out_stall.

module temperature_pid_pwm_controller_core import tppc_pkg::*; #(
	parameter int unsigned WINDOW_LEN      = 10,
	parameter int unsigned ADC_BITS        = 12,
	parameter int unsigned CONTROL_RATE_HZ = 100
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic                sample_valid,
	input  logic [SAMPLE_W-1:0] adc_sample,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [TEMP_W-1:0]   temperature_q8,
	output logic [DRIVE_W-1:0]  drive_q8,
	output logic [PWM_W-1:0]    pwm_compare,
	output logic                fan_on,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WIN  = 3'd1;
	localparam logic [2:0] ST_PID  = 3'd2;
	localparam logic [2:0] ST_FAN  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	cfg_t                  cfg;
	win_req_t              win_req;
	logic                  win_done;
	logic [TEMP_W-1:0]     temperature;
	logic                  pid_start;
	logic                  pid_done;
	logic [DRIVE_W-1:0]    drive;

	logic [2:0]            state_q;
	logic                  kind_q;
	logic                  fan_q;
	logic                  out_valid_q;
	logic [TEMP_W-1:0]     temp_out_q;
	logic [DRIVE_W-1:0]    drive_out_q;
	logic [PWM_W-1:0]      pwm_out_q;
	logic                  fan_out_q;

	logic                  in_acc;
	logic                  out_load;
	logic [TEMP_W-1:0]     sp_t;
	logic [PWM_PROD_W-1:0] pwm_prod;

	assign pready = 1'b1;

	tppc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	assign win_req.start        = in_acc;
	assign win_req.sample_valid = sample_valid;
	assign win_req.sample       = adc_sample;

	tppc_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.ADC_BITS   (ADC_BITS)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (win_req),
		.done        (win_done),
		.temperature (temperature)
	);

	assign pid_start = (state_q == ST_WIN) & win_done & kind_q;

	tppc_pid #(
		.CONTROL_RATE_HZ (CONTROL_RATE_HZ)
	) u_pid (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (pid_start),
		.temperature (temperature),
		.cfg         (cfg),
		.done        (pid_done),
		.drive       (drive)
	);

	assign sp_t     = TEMP_W'({cfg.setpoint, {FRAC_W{1'b0}}});
	assign out_load = (state_q == ST_OUT) & (~out_valid_q | ~out_stall);
	assign pwm_prod = PWM_PROD_W'(drive) * PWM_PROD_W'(PWM_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= 1'b0;
			fan_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						kind_q  <= kind;
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (win_done)
						state_q <= kind_q ? ST_PID : ST_FAN;
				end
				ST_PID: begin
					if (pid_done)
						state_q <= ST_FAN;
				end
				ST_FAN: begin
					// hysteresis: on at setpoint + 1 deg, off at setpoint + 0.5 deg
					if (temperature >= sp_t + TEMP_W'(FAN_ON_MARGIN))
						fan_q <= 1'b1;
					else if (temperature <= sp_t + TEMP_W'(FAN_OFF_MARGIN))
						fan_q <= 1'b0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load)
				out_valid_q <= 1'b1;
			else if (~out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			temp_out_q  <= temperature;
			drive_out_q <= drive;
			pwm_out_q   <= pwm_prod[PWM_W+FRAC_W-1:FRAC_W];
			fan_out_q   <= fan_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign temperature_q8 = temp_out_q;
	assign drive_q8       = drive_out_q;
	assign pwm_compare    = pwm_out_q;
	assign fan_on         = fan_out_q;

endmodule

`default_nettype wire

// ----- design/tppc_checker.sv -----
`default_nettype none

module tppc_checker import tppc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [TEMP_W-1:0]  temperature_q8,
	input  logic [DRIVE_W-1:0] drive_q8,
	input  logic [PWM_W-1:0]   pwm_compare,
	input  logic               fan_on
);

	logic [PWM_PROD_W-1:0] pwm_ref;

	assign pwm_ref = (PWM_PROD_W'(drive_q8) * PWM_PROD_W'(PWM_SCALE)) >> FRAC_W;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(temperature_q8) &&
		$stable(drive_q8) && $stable(pwm_compare) && $stable(fan_on))
		else $error("result beat changed under stall");

	// one item in flight: intake closes right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	a_pwm_tracks_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> PWM_PROD_W'(pwm_compare) == pwm_ref)
		else $error("pwm compare does not match drive");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(drive_q8) <= DRIVE_MAX)
		else $error("drive above full scale");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(temperature_q8) <= TEMP_FULL)
		else $error("temperature above full scale");

endmodule

bind temperature_pid_pwm_controller_core tppc_checker u_tppc_checker (.*);

`default_nettype wire

// ----- tb/temperature_pid_pwm_controller_core_tb.sv -----
`timescale 1ns / 100ps

module temperature_pid_pwm_controller_core_tb;
	import tppc_pkg::*;

	localparam int     WINDOW_DEPTH = 10;
	localparam int     ADC_BITS_TB  = 12;
	localparam int     CONTROL_HZ   = 100;
	localparam int     ADC_FULL     = (1 << ADC_BITS_TB) - 1;
	localparam int     FULL_DEGREES = TEMP_FULL >> FRAC_W;
	localparam longint ACC_CEIL     = 64'hFFFF_FFFF;
	localparam int     PHASES       = 8;
	localparam int     RANDOM_ITEMS = 1650;
	localparam int     IDLE_GUARD   = 24;
	localparam int     LONG_HOLD    = 300;
	localparam int     CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [TEMP_W-1:0]  temp;
		logic [DRIVE_W-1:0] drive;
		logic [PWM_W-1:0]   pwm;
		logic               fan;
	} reading_t;

	// Tracks window, PID and fan state; one expected reading per accepted tick.
	class pid_scoreboard;
		longint              setpoint, gain_p, gain_i, gain_d;
		logic [SAMPLE_W-1:0] sample_ring [WINDOW_DEPTH];
		int                  slot;
		longint              window_sum, temp_held, err_acc, last_err, drive_held;
		bit                  fan_state;
		reading_t            pending_readings [$];
		int                  mismatches;

		function new();
			setpoint = SETPOINT_RST;
			gain_p = GAIN_P_RST;
			gain_i = GAIN_I_RST;
			gain_d = GAIN_D_RST;
			foreach (sample_ring[i])
				sample_ring[i] = '0;
			slot = 0;
			window_sum = 0;
			temp_held = 0;
			err_acc = 0;
			last_err = 0;
			drive_held = 0;
			fan_state = 1'b0;
			mismatches = 0;
		endfunction

		function int pending();
			return pending_readings.size();
		endfunction

		function void set_register(reg_idx_t idx, int unsigned value);
			case (idx)
				REG_SETPOINT: setpoint = value & 32'h0000_00FF;
				REG_GAIN_P:   gain_p = value & 32'h0000_FFFF;
				REG_GAIN_I:   gain_i = value & 32'h0000_FFFF;
				REG_GAIN_D:   gain_d = value & 32'h0000_FFFF;
				default: ;
			endcase
		endfunction

		function void note_tick(logic k, logic v, logic [SAMPLE_W-1:0] s);
			reading_t r;
			longint   sp, e, pid_sum, q;
			if (v) begin
				window_sum = window_sum - sample_ring[slot] + s;
				sample_ring[slot] = s;
				slot = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
				temp_held = window_sum * TEMP_FULL / (ADC_FULL * WINDOW_DEPTH);
			end
			sp = setpoint << FRAC_W;
			if (k) begin
				// above setpoint: drive drops, integrator and last error frozen
				if (sp < temp_held) begin
					drive_held = 0;
				end else begin
					e = sp - temp_held;
					err_acc = (err_acc + e > ACC_CEIL) ? ACC_CEIL : err_acc + e;
					pid_sum = gain_p * e + gain_i * err_acc / CONTROL_HZ
						+ gain_d * (e - last_err) * CONTROL_HZ;
					last_err = e;
					q = pid_sum / (longint'(1) << GAIN_FRAC_W);
					if (pid_sum <= 0)
						drive_held = 0;
					else
						drive_held = (q > longint'(DRIVE_MAX)) ? longint'(DRIVE_MAX) : q;
				end
			end
			if (temp_held >= sp + longint'(FAN_ON_MARGIN))
				fan_state = 1'b1;
			else if (temp_held <= sp + longint'(FAN_OFF_MARGIN))
				fan_state = 1'b0;
			r.temp = TEMP_W'(temp_held);
			r.drive = DRIVE_W'(drive_held);
			r.pwm = PWM_W'((drive_held * PWM_SCALE) >> FRAC_W);
			r.fan = fan_state;
			pending_readings.push_back(r);
		endfunction

		function void check_reading(logic [TEMP_W-1:0] t, logic [DRIVE_W-1:0] d,
				logic [PWM_W-1:0] p, logic f);
			reading_t want;
			bit       bad;
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result beat: temp %0d drive %0d pwm %0d fan %0d",
					$time, t, d, p, f);
				mismatches++;
				return;
			end
			want = pending_readings.pop_front();
			bad = 1'b0;
			if (t !== want.temp) begin
				$display("%0t: temperature_q8 expected %0d, got %0d", $time, want.temp, t);
				bad = 1'b1;
			end
			if (d !== want.drive) begin
				$display("%0t: drive_q8 expected %0d, got %0d", $time, want.drive, d);
				bad = 1'b1;
			end
			if (p !== want.pwm) begin
				$display("%0t: pwm_compare expected %0d, got %0d", $time, want.pwm, p);
				bad = 1'b1;
			end
			if (f !== want.fan) begin
				$display("%0t: fan_on expected %0d, got %0d", $time, want.fan, f);
				bad = 1'b1;
			end
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                kind;
	logic                sample_valid;
	logic [SAMPLE_W-1:0] adc_sample;
	logic                out_valid;
	logic                out_stall;
	logic [TEMP_W-1:0]   temperature_q8;
	logic [DRIVE_W-1:0]  drive_q8;
	logic [PWM_W-1:0]    pwm_compare;
	logic                fan_on;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	pid_scoreboard pid_board;
	int            feed_run_left = 0;
	bit            feed_quiet;
	int            cycle_count = 0;
	int            phase;

	temperature_pid_pwm_controller_core #(
		.WINDOW_LEN(WINDOW_DEPTH),
		.ADC_BITS(ADC_BITS_TB),
		.CONTROL_RATE_HZ(CONTROL_HZ)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.sample_valid(sample_valid),
		.adc_sample(adc_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.temperature_q8(temperature_q8),
		.drive_q8(drive_q8),
		.pwm_compare(pwm_compare),
		.fan_on(fan_on),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			pid_board.check_reading(temperature_q8, drive_q8, pwm_compare, fan_on);

	// result side: random stall before each beat, quiet stretches, two long hold-offs
	initial begin : result_sink
		int hold, run_left, beats;
		bit quiet;
		out_stall = 1'b0;
		run_left = 0;
		beats = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				quiet = ($urandom_range(0, 2) == 0);
				run_left = $urandom_range(16, 80);
			end
			run_left--;
			hold = quiet ? 0 : $urandom_range(0, 11);
			if (beats == 400 || beats == 1100)
				hold = LONG_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			beats++;
		end
	end

	task automatic send_item(input logic k, input logic v, input logic [SAMPLE_W-1:0] s);
		int gap;
		if (feed_run_left == 0) begin
			feed_quiet = ($urandom_range(0, 2) == 0);
			feed_run_left = $urandom_range(16, 80);
		end
		feed_run_left--;
		gap = feed_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		sample_valid <= v;
		adc_sample <= s;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pid_board.note_tick(k, v, s);
		@(negedge clk);
	endtask

	// drain everything outstanding, leaves the block idle at a falling edge
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pid_board.pending() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int unsigned value);
		logic [DATA_W-1:0] field_mask;
		logic [DATA_W-1:0] data;
		field_mask = (idx == REG_SETPOINT) ? 32'h0000_00FF : 32'h0000_FFFF;
		// junk above the field width must be dropped by the block
		data = ($urandom & ~field_mask) | (value & field_mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pid_board.set_register(idx, data);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(input int unsigned sp, input int unsigned kp,
			input int unsigned ki, input int unsigned kd);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
	endtask

	function automatic logic [SAMPLE_W-1:0] sample_near(int center, int spread);
		int v;
		v = center + $urandom_range(0, 2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > ADC_FULL)
			v = ADC_FULL;
		return SAMPLE_W'(v);
	endfunction

	task automatic run_directed();
		send_item(1'b0, 1'b0, 12'hFFF);   // invalid sample leaves the window alone
		send_item(1'b1, 1'b0, 12'h000);   // PID from a cold start
		send_item(1'b0, 1'b1, 12'h000);
		send_item(1'b1, 1'b1, 12'hFFF);   // lands on the setpoint, derivative kick negative
		send_item(1'b1, 1'b1, 12'hFFF);   // above setpoint, drive forced off, fan on
		send_item(1'b1, 1'b0, 12'h000);
		settle_idle();
		write_reg(REG_SETPOINT, 100);     // temperature equals setpoint: fan off
		send_item(1'b0, 1'b0, 12'h000);
		send_item(1'b1, 1'b0, 12'h000);
		settle_idle();
		write_reg(REG_SETPOINT, 99);      // exactly one degree over: fan back on
		send_item(1'b0, 1'b0, 12'h000);
		settle_idle();
		write_all(255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_item(1'b1, 1'b1, 12'h000);   // drive clamps at full scale
		send_item(1'b0, 1'b1, 12'hFFF);
		send_item(1'b1, 1'b1, 12'h555);
		send_item(1'b1, 1'b1, 12'hAAA);
		settle_idle();
		write_all(255, 0, 0, 0);
		send_item(1'b1, 1'b1, 12'h7FF);   // zero gains, zero drive
		send_item(1'b1, 1'b1, 12'h800);
		settle_idle();
		write_all(0, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
		send_item(1'b1, 1'b1, 12'h001);
		send_item(1'b0, 1'b1, 12'h000);
		send_item(1'b1, 1'b0, 12'hFFF);
	endtask

	// mostly valid samples hovering around the setpoint, a quarter pure noise
	task automatic run_random_phase(input int n_items);
		int center, spread, run_left, sp_adc;
		run_left = 0;
		sp_adc = int'(pid_board.setpoint * ADC_FULL / FULL_DEGREES);
		repeat (n_items) begin
			if (run_left == 0) begin
				center = sp_adc + $urandom_range(0, 500) - 400;
				spread = $urandom_range(0, 1) ? 4 : 60;
				run_left = $urandom_range(10, 60);
			end
			run_left--;
			if ($urandom_range(0, 3) == 0)
				send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					SAMPLE_W'($urandom_range(0, ADC_FULL)));
			else
				send_item(1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
					sample_near(center, spread));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = 1'b0;
		sample_valid = 1'b0;
		adc_sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pid_board = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (phase = 0; phase < PHASES; phase++) begin
			settle_idle();
			case (phase)
				0: write_all($urandom_range(20, 80), GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
				1: write_all(255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: write_all(0, 0, 0, 0);
				3: write_all(1, 16'hFFFF, 0, 0);
				4: write_all(254, 0, 16'hFFFF, 0);
				5: write_all($urandom_range(0, 255), 0, 0, 16'hFFFF);
				default: write_all($urandom_range(0, 255), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			endcase
			run_random_phase(RANDOM_ITEMS / PHASES);
		end
		settle_idle();
		if (pid_board.mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
